@@ src/lbs_pkg.sv @@
`timescale 1ns / 1ps

package lbs_pkg;

    // defaults for the top-level parameters
    localparam int MAX_BONES_DEF = 64;
    localparam int FRAC_BITS_DEF = 16;

    // fixed by the word layout
    localparam int INFLUENCES     = 4;
    localparam int WORDS_PER_BONE = 12;
    localparam int WEIGHT_FRAC    = 15;
    localparam int WORD_W         = 32;
    localparam int S_TDATA_W      = 232;
    localparam int M_TDATA_W      = 96;

    // operation carried in tuser
    typedef enum logic {
        OP_LOAD = 1'b0,
        OP_SKIN = 1'b1
    } t_op;

    typedef logic signed [WORD_W-1:0] t_word;

    // clamp a wide signed value to the signed 32-bit range
    function automatic t_word sat32(input logic signed [65:0] x);
        t_word y;
        if (x > 66'sd2147483647) begin
            y = 32'sh7fffffff;
        end else if (x < -66'sd2147483648) begin
            y = 32'sh80000000;
        end else begin
            y = x[31:0];
        end
        return y;
    endfunction

endpackage

@@ src/lbs_ram.sv @@
`timescale 1ns / 1ps

module lbs_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 32,
    parameter int AW    = 6
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read, held while the stage stalls
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ src/linear_blend_skinning_unit.sv @@
`timescale 1ns / 1ps

// Four-bone linear blend skinning engine.
// Slave stream: one word per item. tuser is the op: load writes one matrix
// word (bone, element 0..11, value) into the bone store and gives no result;
// skin blends four bone matrices by their Q1.15 weights and applies the blend
// to (x,y,z,1). Master stream: one word per skin item with skinned x, y, z,
// each Q16.16 saturated to 32 bits.
// Throughput: one word per cycle, loads and skins in any mix, when not stalled.
// A skin word passes the store read, weight multiply, weight sum, position
// multiply and final sum registers before it is shown on the master side,
// and waits longer while the receiver stalls.
// The bone store is split into one bank per influence and element so that all
// 48 matrix words of a vertex are read in the same cycle.
// Reset empties the pipeline; the bone store keeps no reset and a bone must
// be loaded before a vertex uses it.
// When the receiver stalls, the pipeline fills its empty stages and then
// drops o_s_axis_tready; nothing is lost or repeated.

module linear_blend_skinning_unit #(
    parameter int MAX_BONES = lbs_pkg::MAX_BONES_DEF,
    parameter int FRAC_BITS = lbs_pkg::FRAC_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_s_axis_tvalid,
    output logic                         o_s_axis_tready,
    // pos_x, pos_y, pos_z, bone_ids, bone_weights, load_bone, load_element,
    // load_value, zero fill
    input  logic [lbs_pkg::S_TDATA_W-1:0] i_s_axis_tdata,
    // op
    input  logic                         i_s_axis_tuser,
    output logic                         o_m_axis_tvalid,
    input  logic                         i_m_axis_tready,
    // skinned_x, skinned_y, skinned_z
    output logic [lbs_pkg::M_TDATA_W-1:0] o_m_axis_tdata
);

    import lbs_pkg::*;

    localparam int AW = (MAX_BONES > 1) ? $clog2(MAX_BONES) : 1;

    // input fields
    t_word        pos_in [3];
    logic [23:0]  ids;
    logic [63:0]  wts;
    logic [5:0]   ld_bone;
    logic [3:0]   ld_elem;
    logic [31:0]  ld_val;
    logic [8:0]   ld_ext;
    logic         accept;
    logic         load_ok;

    assign pos_in[0] = i_s_axis_tdata[31:0];
    assign pos_in[1] = i_s_axis_tdata[63:32];
    assign pos_in[2] = i_s_axis_tdata[95:64];
    assign ids       = i_s_axis_tdata[119:96];
    assign wts       = {1'b0, i_s_axis_tdata[182:120]};
    assign ld_bone   = i_s_axis_tdata[188:183];
    assign ld_elem   = i_s_axis_tdata[192:189];
    assign ld_val    = i_s_axis_tdata[224:193];
    assign ld_ext    = {3'b000, ld_bone};

    // stage enables, from the output back
    logic r_v1, r_v2, r_v3, r_v4, r_v5;
    logic en1, en2, en3, en4, en5;

    assign en5 = !r_v5 || i_m_axis_tready;
    assign en4 = !r_v4 || en5;
    assign en3 = !r_v3 || en4;
    assign en2 = !r_v2 || en3;
    assign en1 = !r_v1 || en2;

    assign o_s_axis_tready = en1;
    assign accept  = i_s_axis_tvalid && en1;
    assign load_ok = accept && (t_op'(i_s_axis_tuser) == OP_LOAD)
                     && (ld_ext < 9'(MAX_BONES)) && (ld_elem < 4'(WORDS_PER_BONE));

    // bone store: one bank per influence and element
    logic [8:0]    id_ext [INFLUENCES];
    logic          id_ok  [INFLUENCES];
    logic [15:0]   w_in   [INFLUENCES];
    logic [31:0]   rd     [INFLUENCES][WORDS_PER_BONE];

    genvar gi, ge;
    generate
        for (gi = 0; gi < INFLUENCES; gi++) begin : g_inf
            assign id_ext[gi] = {3'b000, ids[6*gi +: 6]};
            assign id_ok[gi]  = id_ext[gi] < 9'(MAX_BONES);
            assign w_in[gi]   = wts[16*gi +: 16];
            for (ge = 0; ge < WORDS_PER_BONE; ge++) begin : g_elem
                lbs_ram #(
                    .DEPTH (MAX_BONES),
                    .WIDTH (WORD_W),
                    .AW    (AW)
                ) u_ram (
                    .i_clk   (i_clk),
                    .i_we    (load_ok && (ld_elem == 4'(ge))),
                    .i_waddr (ld_ext[AW-1:0]),
                    .i_wdata (ld_val),
                    .i_re    (en1),
                    .i_raddr (id_ext[gi][AW-1:0]),
                    .o_rdata (rd[gi][ge])
                );
            end
        end
    endgenerate

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else begin
            if (en1) r_v1 <= accept && (t_op'(i_s_axis_tuser) == OP_SKIN);
            if (en2) r_v2 <= r_v1;
            if (en3) r_v3 <= r_v2;
            if (en4) r_v4 <= r_v3;
            if (en5) r_v5 <= r_v4;
        end
    end

    // stage 1: weights (zeroed for out-of-range bones) and position
    logic [15:0] r_w1 [INFLUENCES];
    t_word       r_pos1 [3];

    always_ff @(posedge i_clk) begin
        if (en1) begin
            for (int i = 0; i < INFLUENCES; i++) begin
                r_w1[i] <= id_ok[i] ? w_in[i] : 16'd0;
            end
            for (int c = 0; c < 3; c++) begin
                r_pos1[c] <= pos_in[c];
            end
        end
    end

    // stage 2: matrix word times weight
    logic signed [48:0] n_p2 [INFLUENCES][WORDS_PER_BONE];
    logic signed [48:0] r_p2 [INFLUENCES][WORDS_PER_BONE];
    t_word              r_pos2 [3];

    always_comb begin
        for (int i = 0; i < INFLUENCES; i++) begin
            for (int e = 0; e < WORDS_PER_BONE; e++) begin
                n_p2[i][e] = $signed(rd[i][e]) * $signed({1'b0, r_w1[i]});
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en2) begin
            r_p2 <= n_p2;
            r_pos2 <= r_pos1;
        end
    end

    // stage 3: sum influences, round and clamp the blended matrix
    logic signed [50:0] acc [WORDS_PER_BONE];
    logic signed [50:0] acc_rnd [WORDS_PER_BONE];
    t_word              n_b3 [WORDS_PER_BONE];
    t_word              r_b3 [WORDS_PER_BONE];
    t_word              r_pos3 [3];

    always_comb begin
        for (int e = 0; e < WORDS_PER_BONE; e++) begin
            acc[e] = '0;
            for (int i = 0; i < INFLUENCES; i++) begin
                acc[e] = acc[e] + 51'(r_p2[i][e]);
            end
            acc_rnd[e] = (acc[e] + (51'sd1 <<< (WEIGHT_FRAC - 1))) >>> WEIGHT_FRAC;
            n_b3[e]    = sat32(66'(acc_rnd[e]));
        end
    end

    always_ff @(posedge i_clk) begin
        if (en3) begin
            r_b3 <= n_b3;
            r_pos3 <= r_pos2;
        end
    end

    // stage 4: blended rotation times position
    logic signed [63:0] n_m4 [3][3];
    logic signed [63:0] r_m4 [3][3];
    t_word              r_t4 [3];

    always_comb begin
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
                n_m4[r][c] = r_b3[4*r + c] * r_pos3[c];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en4) begin
            r_m4 <= n_m4;
            for (int r = 0; r < 3; r++) begin
                r_t4[r] <= r_b3[4*r + 3];
            end
        end
    end

    // stage 5: round terms, add translation, clamp into the output word
    logic signed [63:0] term [3][3];
    logic signed [65:0] row_sum [3];
    t_word              n_out [3];
    t_word              r_out [3];

    always_comb begin
        for (int r = 0; r < 3; r++) begin
            row_sum[r] = 66'(r_t4[r]);
            for (int c = 0; c < 3; c++) begin
                term[r][c] = (r_m4[r][c] + (64'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
                row_sum[r] = row_sum[r] + 66'(term[r][c]);
            end
            n_out[r] = sat32(row_sum[r]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en5) begin
            r_out <= n_out;
        end
    end

    assign o_m_axis_tvalid = r_v5;
    assign o_m_axis_tdata  = {r_out[2], r_out[1], r_out[0]};

endmodule

@@ src/lbs_checker.sv @@
`timescale 1ns / 1ps

module lbs_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          o_s_axis_tready,
    input logic                          o_m_axis_tvalid,
    input logic                          i_m_axis_tready,
    input logic [lbs_pkg::M_TDATA_W-1:0] o_m_axis_tdata
);

    // reset empties the output
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("output valid after reset");

    // input backpressure only when the output is stalled
    a_ready_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_axis_tready |-> (o_m_axis_tvalid && !i_m_axis_tready))
        else $error("input stalled without output stall");

    // hold a stalled result word
    a_valid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !i_m_axis_tready) |=> o_m_axis_tvalid)
        else $error("output word dropped");

    a_data_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !i_m_axis_tready) |=> $stable(o_m_axis_tdata))
        else $error("output word changed while stalled");

endmodule

bind linear_blend_skinning_unit lbs_checker u_lbs_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata)
);

@@ verif/lbs_skin_checker.sv @@
`timescale 1ns / 1ps

// Watch both streams, keep a shadow copy of the bone store and compare every
// skinned vertex against the blend worked out from that copy.
module lbs_skin_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_tvalid,
    input  logic                          i_s_tready,
    input  logic [lbs_pkg::S_TDATA_W-1:0] i_s_tdata,
    input  logic                          i_s_tuser,
    input  logic                          i_m_tvalid,
    input  logic                          i_m_tready,
    input  logic [lbs_pkg::M_TDATA_W-1:0] i_m_tdata,
    output int                            o_pending,
    output int                            o_errors
);
    import lbs_pkg::*;

    localparam int BONES = MAX_BONES_DEF;
    localparam int FRAC  = FRAC_BITS_DEF;

    typedef struct {
        t_word x;
        t_word y;
        t_word z;
    } t_vertex;

    t_word   shadow_bones [BONES*WORDS_PER_BONE];
    t_vertex skinned_queue [$];

    initial begin
        o_errors  = 0;
        o_pending = 0;
        foreach (shadow_bones[k]) shadow_bones[k] = '0;
    end

    function automatic t_word clamp_word(input longint v);
        if (v > 64'sd2147483647) return 32'sh7fffffff;
        if (v < -64'sd2147483648) return 32'sh80000000;
        return t_word'(v[31:0]);
    endfunction

    // blend the four bone matrices, then transform (x,y,z,1)
    function automatic t_vertex skin_vertex(input logic [S_TDATA_W-1:0] d);
        t_word       blend [WORDS_PER_BONE];
        t_word       pos [3];
        t_word       res [3];
        longint      acc;
        logic [5:0]  id;
        logic [15:0] w;
        t_vertex     v;
        pos[0] = d[31:0];
        pos[1] = d[63:32];
        pos[2] = d[95:64];
        for (int e = 0; e < WORDS_PER_BONE; e++) begin
            acc = 0;
            for (int i = 0; i < INFLUENCES; i++) begin
                id = d[96 + 6*i +: 6];
                // the last weight has only 15 bits in the word
                w  = (i == 3) ? {1'b0, d[168 +: 15]} : d[120 + 16*i +: 16];
                if (id < BONES)
                    acc += longint'(shadow_bones[id*WORDS_PER_BONE + e]) * longint'(w);
            end
            blend[e] = clamp_word((acc + (64'sd1 <<< (WEIGHT_FRAC-1))) >>> WEIGHT_FRAC);
        end
        for (int r = 0; r < 3; r++) begin
            acc = longint'(blend[4*r+3]);
            for (int c = 0; c < 3; c++)
                acc += (longint'(blend[4*r+c]) * longint'(pos[c])
                        + (64'sd1 <<< (FRAC-1))) >>> FRAC;
            res[r] = clamp_word(acc);
        end
        v.x = res[0];
        v.y = res[1];
        v.z = res[2];
        return v;
    endfunction

    task automatic report_mismatch(input string what, input t_word got, input t_word want);
        $display("[%0t] mismatch on %s: got %h, expected %h", $realtime, what, got, want);
        o_errors++;
    endtask

    // track accepted words on both sides
    always @(posedge i_clk) begin
        t_vertex want;
        logic [5:0] bone;
        logic [3:0] elem;
        if (i_rst_n) begin
            if (i_s_tvalid && i_s_tready) begin
                if (t_op'(i_s_tuser) == OP_LOAD) begin
                    bone = i_s_tdata[188:183];
                    elem = i_s_tdata[192:189];
                    if (bone < BONES && elem < WORDS_PER_BONE)
                        shadow_bones[bone*WORDS_PER_BONE + elem] = i_s_tdata[224:193];
                end else begin
                    skinned_queue.push_back(skin_vertex(i_s_tdata));
                end
            end
            if (i_m_tvalid && i_m_tready) begin
                if (skinned_queue.size() == 0) begin
                    report_mismatch("unexpected word", i_m_tdata[31:0], '0);
                end else begin
                    want = skinned_queue.pop_front();
                    if (i_m_tdata[31:0] !== want.x)
                        report_mismatch("skinned_x", i_m_tdata[31:0], want.x);
                    if (i_m_tdata[63:32] !== want.y)
                        report_mismatch("skinned_y", i_m_tdata[63:32], want.y);
                    if (i_m_tdata[95:64] !== want.z)
                        report_mismatch("skinned_z", i_m_tdata[95:64], want.z);
                end
            end
            o_pending <= skinned_queue.size();
        end
    end

endmodule

@@ verif/tb_linear_blend_skinning_unit.sv @@
`timescale 1ns / 1ps

module tb_linear_blend_skinning_unit;
    import lbs_pkg::*;

    localparam int BONES       = MAX_BONES_DEF;
    localparam int ITEM_TARGET = 900;
    localparam int CALM_AFTER  = 760;
    localparam int CYCLE_LIMIT = 400000;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n;
    logic                   i_s_axis_tvalid;
    logic                   o_s_axis_tready;
    logic [S_TDATA_W-1:0]   i_s_axis_tdata;
    logic                   i_s_axis_tuser;
    logic                   o_m_axis_tvalid;
    logic                   i_m_axis_tready;
    logic [M_TDATA_W-1:0]   o_m_axis_tdata;

    int   pending_vertices;
    int   error_count;
    int   cycle_count = 0;
    int   items_sent = 0;
    bit   calm = 1'b0;
    bit   loaded [BONES][WORDS_PER_BONE];

    always #4 i_clk = ~i_clk;

    linear_blend_skinning_unit i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_s_axis_tvalid(i_s_axis_tvalid),
        .o_s_axis_tready(o_s_axis_tready),
        .i_s_axis_tdata (i_s_axis_tdata),
        .i_s_axis_tuser (i_s_axis_tuser),
        .o_m_axis_tvalid(o_m_axis_tvalid),
        .i_m_axis_tready(i_m_axis_tready),
        .o_m_axis_tdata (o_m_axis_tdata)
    );

    lbs_skin_checker i_checker (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_tvalid(i_s_axis_tvalid),
        .i_s_tready(o_s_axis_tready),
        .i_s_tdata (i_s_axis_tdata),
        .i_s_tuser (i_s_axis_tuser),
        .i_m_tvalid(o_m_axis_tvalid),
        .i_m_tready(i_m_axis_tready),
        .i_m_tdata (o_m_axis_tdata),
        .o_pending (pending_vertices),
        .o_errors  (error_count)
    );

    // stop a hung run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // stall the receiver in random bursts
    initial begin
        i_m_axis_tready <= 1'b0;
        @(posedge i_rst_n);
        forever begin
            if (!calm && $urandom_range(0, 2) == 0) begin
                i_m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 19)) @(posedge i_clk);
            end
            i_m_axis_tready <= 1'b1;
            repeat ($urandom_range(1, 30)) @(posedge i_clk);
        end
    end

    function automatic logic [S_TDATA_W-1:0] pack_word(
        input t_word x, input t_word y, input t_word z, input logic [23:0] ids,
        input logic [62:0] wts, input logic [5:0] bone, input logic [3:0] elem,
        input t_word val);
        return {7'b0, val, elem, bone, wts, ids, z, y, x};
    endfunction

    // mix of full-range, extreme and modest Q16.16 values
    function automatic t_word pick_value();
        case ($urandom_range(0, 3))
            0: return $urandom;
            1: return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
            2: return t_word'($urandom_range(0, 1 << 18)) - (1 << 17);
            default: return t_word'($urandom_range(0, 1 << 25)) - (1 << 24);
        endcase
    endfunction

    function automatic bit bone_ready(input int b);
        for (int e = 0; e < WORDS_PER_BONE; e++)
            if (!loaded[b][e]) return 1'b0;
        return 1'b1;
    endfunction

    // present one word, with an optional gap first, and wait for acceptance
    task automatic send_word(input t_op op, input logic [S_TDATA_W-1:0] d);
        if (!calm && $urandom_range(0, 5) == 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= d;
        i_s_axis_tuser  <= op;
        do @(posedge i_clk); while (!o_s_axis_tready);
        if (op == OP_LOAD && d[188:183] < BONES && d[192:189] < WORDS_PER_BONE)
            loaded[d[188:183]][d[192:189]] = 1'b1;
        items_sent++;
    endtask

    task automatic load_bone(input logic [5:0] bone, input t_word vals [WORDS_PER_BONE]);
        for (int e = 0; e < WORDS_PER_BONE; e++)
            send_word(OP_LOAD, pack_word($urandom, $urandom, $urandom, 24'($urandom),
                      63'({$urandom, $urandom}), bone, e[3:0], vals[e]));
    endtask

    task automatic skin(input t_word x, input t_word y, input t_word z,
                        input logic [23:0] ids, input logic [62:0] wts);
        send_word(OP_SKIN, pack_word(x, y, z, ids, wts, 6'($urandom), 4'($urandom),
                                     $urandom));
    endtask

    // random skin item over bones that are fully loaded
    task automatic random_skin();
        int          ready_ids [$];
        logic [23:0] ids;
        logic [62:0] wts;
        for (int b = 0; b < BONES; b++)
            if (bone_ready(b)) ready_ids.push_back(b);
        for (int i = 0; i < INFLUENCES; i++)
            ids[6*i +: 6] = 6'(ready_ids[$urandom_range(0, ready_ids.size() - 1)]);
        case ($urandom_range(0, 3))
            0: wts = 63'({$urandom, $urandom});
            1: begin
                wts = '0;
                wts[16*$urandom_range(0, 2) +: 16] = 16'h8000;
            end
            default: begin
                for (int i = 0; i < 3; i++)
                    wts[16*i +: 16] = 16'($urandom_range(0, 16'h3000));
                wts[62:48] = 15'($urandom_range(0, 15'h3000));
            end
        endcase
        skin(pick_value(), pick_value(), pick_value(), ids, wts);
    endtask

    initial begin
        t_word vals [WORDS_PER_BONE];
        logic [5:0] bone;
        i_rst_n         <= 1'b0;
        i_s_axis_tvalid <= 1'b0;
        i_s_axis_tdata  <= '0;
        i_s_axis_tuser  <= OP_LOAD;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // identity on bone 0, alternating extremes on bone 63
        foreach (vals[e]) vals[e] = (e % 5 == 0) ? 32'sh00010000 : 32'sh0;
        load_bone(6'd0, vals);
        foreach (vals[e]) vals[e] = (e % 2) ? 32'sh80000000 : 32'sh7fffffff;
        load_bone(6'd63, vals);
        // out-of-range elements are dropped
        send_word(OP_LOAD, pack_word(0, 0, 0, 0, 0, 6'd0, 4'd12, 32'sh12345678));
        send_word(OP_LOAD, pack_word(0, 0, 0, 0, 0, 6'd0, 4'd15, 32'shdeadbeef));
        skin(32'sh7fffffff, 32'sh80000000, 32'sh00018000, 24'd0, 63'h8000);
        skin(32'sh00000001, 32'shffffffff, 32'sh0, 24'd0, 63'h4000);
        skin(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 24'hffffff, {15'h7fff, {3{16'hffff}}});
        skin(32'sh80000000, 32'sh80000000, 32'sh80000000, 24'hffffff, 63'h0001_0001_0001);
        skin(32'sh00010000, 32'sh00020000, 32'sh00030000, {6'd63, 6'd0, 6'd63, 6'd0},
             {15'h0, 16'h0, 16'h0, 16'h0});
        skin($urandom, $urandom, $urandom, {6'd0, 6'd63, 6'd0, 6'd63},
             {15'h4000, 16'h2000, 16'h1000, 16'h8000});

        // random part: whole-bone loads, stray single loads and skins
        while (items_sent < ITEM_TARGET) begin
            if (items_sent > CALM_AFTER) calm = 1'b1;
            case ($urandom_range(0, 9))
                0, 1: begin
                    bone = 6'($urandom);
                    foreach (vals[e]) vals[e] = pick_value();
                    load_bone(bone, vals);
                end
                2: send_word(OP_LOAD, pack_word($urandom, $urandom, $urandom, 24'($urandom),
                             63'({$urandom, $urandom}), 6'($urandom), 4'($urandom),
                             pick_value()));
                default: random_skin();
            endcase
        end
        i_s_axis_tvalid <= 1'b0;

        // drain
        while (pending_vertices != 0 || o_m_axis_tvalid) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (error_count == 0 && pending_vertices == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
src/lbs_pkg.sv
src/lbs_ram.sv
src/linear_blend_skinning_unit.sv
src/lbs_checker.sv
verif/lbs_skin_checker.sv
verif/tb_linear_blend_skinning_unit.sv
